// ===== hw/rtl/vpf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_pkg
// Shared types and constants for the VLAN policy filter with counters.
// ---------------------------------------------------------------------------
package vpf_pkg;

    localparam int VLAN_COUNT  = 4096;
    localparam int COUNT_WIDTH = 32;
    localparam int CNT_DEPTH   = VLAN_COUNT + 1;
    localparam int VID_W       = $clog2(VLAN_COUNT);
    localparam int KEY_W       = $clog2(CNT_DEPTH);

    localparam logic [15:0] TPID_CTAG      = 16'h8100;
    localparam logic [15:0] TPID_STAG      = 16'h88A8;
    localparam logic [15:0] VID_MASK       = 16'h0fff;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] TAGGED_HDR_LEN = 16'd18;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_POLICY = 1'b1;

    localparam logic [1:0] ENTRY_ABSENT = 2'd0;
    localparam logic [1:0] ENTRY_PASS   = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_POLICY,
        OP_COUNT,
        OP_NOCOUNT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [1:0]       action;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] seen;
        logic [COUNT_WIDTH-1:0] pass;
        logic [COUNT_WIDTH-1:0] drop;
    } cnt_word_t;

    localparam int CNT_WORD_W = $bits(cnt_word_t);

endpackage

// ===== hw/rtl/vlan_policy_filter_with_counters_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vlan_policy_filter_with_counters_top
// VLAN ID filter table with per-key seen/pass/drop counters.
// ---------------------------------------------------------------------------
// Path: a frame transaction goes through the command queue, then the table
//   and counter read, then the counter update into the output register.
// Flow: the back end takes no new frame while it writes back the counter RAM
//   for the last one; a policy write is applied straight from idle.
// Reset: asynchronous; afterwards a clearing pass over the 4097 counter words
//   zeroes them and marks every policy entry absent, with full held high.
// ---------------------------------------------------------------------------
module vlan_policy_filter_with_counters_top (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [15:0] tag_control,
    input  logic [11:0] policy_vlan,
    input  logic [1:0]  policy_action,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        verdict,
    output logic        counted,
    output logic [12:0] counter_key,
    output logic [31:0] seen_count,
    output logic [31:0] pass_count,
    output logic [31:0] drop_count
);

    // Front end -> command queue
    logic          fq_push;
    vpf_pkg::cmd_t fq_cmd;
    logic          fq_full;

    // Command queue -> back end
    logic          bq_empty;
    logic          bq_pop;
    vpf_pkg::cmd_t bq_head;

    // Back end holds off new transactions during the clearing pass
    logic          clearing;

    // Classifier: decodes frame headers into count / no-count commands and
    // passes policy writes straight through.
    vpf_front u_front (
        .push          (push),
        .full          (full),
        .kind          (kind),
        .frame_length  (frame_length),
        .ether_type    (ether_type),
        .tag_control   (tag_control),
        .policy_vlan   (policy_vlan),
        .policy_action (policy_action),
        .q_full        (fq_full),
        .clearing      (clearing),
        .q_push        (fq_push),
        .q_cmd         (fq_cmd)
    );

    // Decouples the classifier from the table/counter engine; input transactions
    // keep flowing, until the queue fills, while a result waits to be popped.
    vpf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .push_cmd (fq_cmd),
        .full     (fq_full),
        .pop      (bq_pop),
        .empty    (bq_empty),
        .head     (bq_head)
    );

    // Engine: policy RAM, counter RAM and the output register.
    vpf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (bq_empty),
        .q_head      (bq_head),
        .q_pop       (bq_pop),
        .clearing    (clearing),
        .empty       (empty),
        .pop         (pop),
        .verdict     (verdict),
        .counted     (counted),
        .counter_key (counter_key),
        .seen_count  (seen_count),
        .pass_count  (pass_count),
        .drop_count  (drop_count)
    );

endmodule

// ===== hw/rtl/vpf_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/vpf_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_front
// Accepts input transactions and classifies them into back-end commands.
// ---------------------------------------------------------------------------
module vpf_front (
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [15:0]        frame_length,
    input  logic [15:0]        ether_type,
    input  logic [15:0]        tag_control,
    input  logic [11:0]        policy_vlan,
    input  logic [1:0]         policy_action,
    input  logic               q_full,
    input  logic               clearing,
    output logic               q_push,
    output vpf_pkg::cmd_t      q_cmd
);

    logic        accept;
    logic        tpid_match;
    logic [11:0] vid;
    logic        vid_ok;
    logic        pol_ok;

    assign full   = q_full || clearing;
    assign accept = push && !full;

    assign tpid_match = (ether_type == vpf_pkg::TPID_CTAG)
                     || (ether_type == vpf_pkg::TPID_STAG);
    assign vid    = 12'(tag_control & vpf_pkg::VID_MASK);
    assign vid_ok = 32'(vid) < vpf_pkg::VLAN_COUNT;
    assign pol_ok = 32'(policy_vlan) < vpf_pkg::VLAN_COUNT;

    always_comb
    begin
        q_cmd.action = policy_action;
        q_cmd.key    = '0;
        q_cmd.op     = vpf_pkg::OP_NOCOUNT;
        q_push       = accept;
        if (kind == vpf_pkg::KIND_POLICY)
        begin
            q_cmd.op  = vpf_pkg::OP_POLICY;
            q_cmd.key = vpf_pkg::KEY_W'(policy_vlan);
            // writes outside the table are dropped here
            q_push    = accept && pol_ok;
        end
        else if (frame_length < vpf_pkg::ETH_HDR_LEN)
        begin
            q_cmd.op = vpf_pkg::OP_NOCOUNT;
        end
        else if (!tpid_match)
        begin
            q_cmd.op  = vpf_pkg::OP_COUNT;
            q_cmd.key = vpf_pkg::KEY_W'(vpf_pkg::VLAN_COUNT);
        end
        else if (frame_length < vpf_pkg::TAGGED_HDR_LEN || !vid_ok)
        begin
            q_cmd.op = vpf_pkg::OP_NOCOUNT;
        end
        else
        begin
            q_cmd.op  = vpf_pkg::OP_COUNT;
            q_cmd.key = vpf_pkg::KEY_W'(vid);
        end
    end

endmodule

// ===== hw/rtl/vpf_cmd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_cmd_queue
// Short command FIFO between the classifier and the table/counter engine.
// ---------------------------------------------------------------------------
module vpf_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vpf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output vpf_pkg::cmd_t head
);

    vpf_pkg::cmd_t                  entry_reg [vpf_pkg::QUEUE_DEPTH];
    logic [vpf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [vpf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [vpf_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = count_reg == vpf_pkg::QCNT_W'(vpf_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == vpf_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + vpf_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == vpf_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + vpf_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + vpf_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - vpf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/vpf_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_back
// Policy table and counter engine: clear pass, lookup, read-modify-write.
// ---------------------------------------------------------------------------
module vpf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  vpf_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          clearing,
    output logic          empty,
    input  logic          pop,
    output logic          verdict,
    output logic          counted,
    output logic [12:0]   counter_key,
    output logic [31:0]   seen_count,
    output logic [31:0]   pass_count,
    output logic [31:0]   drop_count
);

    vpf_pkg::state_t              state_reg, state_next;
    logic [vpf_pkg::KEY_W-1:0]    clr_reg, clr_next;
    vpf_pkg::cmd_t                cmd_reg, cmd_next;

    // RAM controls
    logic                             pol_we;
    logic [vpf_pkg::VID_W-1:0]        pol_waddr;
    logic [1:0]                       pol_wdata;
    logic [1:0]                       pol_rdata;
    logic                             cnt_we;
    logic [vpf_pkg::KEY_W-1:0]        cnt_waddr;
    vpf_pkg::cnt_word_t               cnt_wdata;
    logic [vpf_pkg::CNT_WORD_W-1:0]   cnt_rdata_raw;
    vpf_pkg::cnt_word_t               cnt_rdata;
    logic                             rd_en;
    logic                             load_out;

    logic                             out_valid_reg;
    logic                             verdict_reg;
    logic                             counted_reg;
    logic [12:0]                      key_reg;
    logic [31:0]                      seen_reg, pass_reg, drop_reg;

    logic                             take_frame;
    logic                             pass_ok;
    logic                             is_count;
    vpf_pkg::cnt_word_t               cnt_upd;

    assign cnt_rdata = vpf_pkg::cnt_word_t'(cnt_rdata_raw);
    assign is_count  = cmd_reg.op == vpf_pkg::OP_COUNT;
    assign pass_ok   = (cmd_reg.key == vpf_pkg::KEY_W'(vpf_pkg::VLAN_COUNT))
                    || (pol_rdata == vpf_pkg::ENTRY_ABSENT)
                    || (pol_rdata == vpf_pkg::ENTRY_PASS);

    // frame may start only if the output slot is free when it lands
    assign take_frame = !q_empty && (q_head.op != vpf_pkg::OP_POLICY)
                     && (!out_valid_reg || pop);

    always_comb
    begin
        cnt_upd.seen = cnt_rdata.seen + vpf_pkg::COUNT_WIDTH'(1);
        cnt_upd.pass = pass_ok ? cnt_rdata.pass + vpf_pkg::COUNT_WIDTH'(1) : cnt_rdata.pass;
        cnt_upd.drop = pass_ok ? cnt_rdata.drop : cnt_rdata.drop + vpf_pkg::COUNT_WIDTH'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            vpf_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + vpf_pkg::KEY_W'(1);
                if (clr_reg == vpf_pkg::KEY_W'(vpf_pkg::VLAN_COUNT))
                begin
                    state_next = vpf_pkg::ST_IDLE;
                end
            end
            vpf_pkg::ST_IDLE:
            begin
                if (take_frame)
                begin
                    cmd_next   = q_head;
                    state_next = vpf_pkg::ST_UPDATE;
                end
            end
            vpf_pkg::ST_UPDATE:
            begin
                state_next = vpf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vpf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        pol_we    = 1'b0;
        pol_waddr = q_head.key[vpf_pkg::VID_W-1:0];
        pol_wdata = q_head.action;
        cnt_we    = 1'b0;
        cnt_waddr = cmd_reg.key;
        cnt_wdata = cnt_upd;
        rd_en     = 1'b0;
        q_pop     = 1'b0;
        load_out  = 1'b0;
        clearing  = 1'b0;
        case (state_reg)
            vpf_pkg::ST_CLEAR:
            begin
                clearing  = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                pol_we    = 32'(clr_reg) < vpf_pkg::VLAN_COUNT;
                pol_waddr = clr_reg[vpf_pkg::VID_W-1:0];
                pol_wdata = vpf_pkg::ENTRY_ABSENT;
            end
            vpf_pkg::ST_IDLE:
            begin
                if (!q_empty && q_head.op == vpf_pkg::OP_POLICY)
                begin
                    pol_we = 1'b1;
                    q_pop  = 1'b1;
                end
                else if (take_frame)
                begin
                    rd_en = 1'b1;
                    q_pop = 1'b1;
                end
            end
            vpf_pkg::ST_UPDATE:
            begin
                cnt_we   = is_count;
                load_out = 1'b1;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vpf_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load_out)
        begin
            verdict_reg <= is_count ? pass_ok : 1'b1;
            counted_reg <= is_count;
            key_reg     <= is_count ? 13'(cmd_reg.key) : 13'd0;
            seen_reg    <= is_count ? 32'(cnt_upd.seen) : 32'd0;
            pass_reg    <= is_count ? 32'(cnt_upd.pass) : 32'd0;
            drop_reg    <= is_count ? 32'(cnt_upd.drop) : 32'd0;
        end
    end

    assign empty       = !out_valid_reg;
    assign verdict     = verdict_reg;
    assign counted     = counted_reg;
    assign counter_key = key_reg;
    assign seen_count  = seen_reg;
    assign pass_count  = pass_reg;
    assign drop_count  = drop_reg;

    vpf_ram #(
        .WIDTH(2),
        .DEPTH(vpf_pkg::VLAN_COUNT)
    ) u_policy_ram (
        .clk   (clk),
        .we    (pol_we),
        .waddr (pol_waddr),
        .wdata (pol_wdata),
        .re    (rd_en),
        .raddr (q_head.key[vpf_pkg::VID_W-1:0]),
        .rdata (pol_rdata)
    );

    vpf_ram #(
        .WIDTH(vpf_pkg::CNT_WORD_W),
        .DEPTH(vpf_pkg::CNT_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (q_head.key),
        .rdata (cnt_rdata_raw)
    );

endmodule

// ===== sim/vpf_filter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpf_filter_checker
// Watches both queue sides of the VLAN policy filter, predicts each frame
// verdict and counter update, and compares against the popped results.
// ---------------------------------------------------------------------------
module vpf_filter_checker
    import vpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        kind,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [15:0] tag_control,
    input  logic [11:0] policy_vlan,
    input  logic [1:0]  policy_action,
    input  logic        empty,
    input  logic        pop,
    input  logic        verdict,
    input  logic        counted,
    input  logic [12:0] counter_key,
    input  logic [31:0] seen_count,
    input  logic [31:0] pass_count,
    input  logic [31:0] drop_count,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic        verdict;
        logic        counted;
        logic [12:0] key;
        logic [31:0] seen;
        logic [31:0] pass;
        logic [31:0] drop;
    } frame_result_t;

    logic [1:0]  policy_entry [0:VLAN_COUNT-1];
    logic [31:0] seen_tally   [0:VLAN_COUNT];
    logic [31:0] pass_tally   [0:VLAN_COUNT];
    logic [31:0] drop_tally   [0:VLAN_COUNT];

    frame_result_t expected_results [$];

    // slot VLAN_COUNT holds the untagged key; -1 means not counted
    function automatic frame_result_t classify_frame(input logic [15:0] flen,
                                                     input logic [15:0] etype,
                                                     input logic [15:0] tci);
        frame_result_t r;
        int            slot;
        r         = '0;
        r.verdict = 1'b1;
        slot      = -1;
        if (flen < ETH_HDR_LEN)
            slot = -1;
        else if (etype != TPID_CTAG && etype != TPID_STAG)
            slot = VLAN_COUNT;
        else if (flen >= TAGGED_HDR_LEN && int'(tci & VID_MASK) < VLAN_COUNT)
            slot = int'(tci & VID_MASK);
        if (slot >= 0) begin
            seen_tally[slot] = seen_tally[slot] + 32'd1;
            if (slot == VLAN_COUNT || policy_entry[slot] == ENTRY_ABSENT
                    || policy_entry[slot] == ENTRY_PASS)
                pass_tally[slot] = pass_tally[slot] + 32'd1;
            else begin
                drop_tally[slot] = drop_tally[slot] + 32'd1;
                r.verdict = 1'b0;
            end
            r.counted = 1'b1;
            r.key     = slot[12:0];
            r.seen    = seen_tally[slot];
            r.pass    = pass_tally[slot];
            r.drop    = drop_tally[slot];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        frame_result_t want;
        frame_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < VLAN_COUNT; i++)
                policy_entry[i] = ENTRY_ABSENT;
            for (int i = 0; i <= VLAN_COUNT; i++) begin
                seen_tally[i] = '0;
                pass_tally[i] = '0;
                drop_tally[i] = '0;
            end
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (pop && !empty) begin
                got = {verdict, counted, counter_key, seen_count, pass_count, drop_count};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: verdict=%0d counted=%0d key=%0d",
                                 got.verdict, got.counted, got.key);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected verdict=%0d counted=%0d key=%0d seen=%0d pass=%0d drop=%0d",
                                     want.verdict, want.counted, want.key,
                                     want.seen, want.pass, want.drop);
                            $display("  actual   verdict=%0d counted=%0d key=%0d seen=%0d pass=%0d drop=%0d",
                                     got.verdict, got.counted, got.key,
                                     got.seen, got.pass, got.drop);
                        end
                        mismatches++;
                    end
                end
            end
            if (push && !full) begin
                if (kind == KIND_POLICY) begin
                    if (int'(policy_vlan) < VLAN_COUNT)
                        policy_entry[policy_vlan] = policy_action;
                end else begin
                    expected_results.push_back(
                        classify_frame(frame_length, ether_type, tag_control));
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/vlan_policy_filter_with_counters_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vlan_policy_filter_with_counters_top_tb
// Drives frame header and policy write transactions into the filter under
// several idle/stall mixes; the checker predicts verdicts and counters.
// ---------------------------------------------------------------------------
module vlan_policy_filter_with_counters_top_tb;

    import vpf_pkg::*;

    // policy write actions
    localparam logic [1:0] ACT_REMOVE = 2'd0;
    localparam logic [1:0] ACT_PASS   = 2'd1;
    localparam logic [1:0] ACT_DROP   = 2'd2;
    localparam logic [1:0] ACT_ODD    = 2'd3;   // unnamed value, drops

    localparam int RANDOM_PER_PHASE = 350;
    localparam int DRAIN_CYCLES     = 20;
    // clearing pass plus ~1400 transactions, some phases with long gaps and stalls
    localparam int CYCLE_LIMIT      = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [15:0] tag_control;
    logic [11:0] policy_vlan;
    logic [1:0]  policy_action;
    logic        empty;
    logic        pop;
    logic        verdict;
    logic        counted;
    logic [12:0] counter_key;
    logic [31:0] seen_count;
    logic [31:0] pass_count;
    logic [31:0] drop_count;

    int mismatches;
    int outstanding;

    // percent of cycles the sender idles / the receiver stalls
    int idle_pct;
    int stall_pct;

    vlan_policy_filter_with_counters_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .frame_length  (frame_length),
        .ether_type    (ether_type),
        .tag_control   (tag_control),
        .policy_vlan   (policy_vlan),
        .policy_action (policy_action),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .counted       (counted),
        .counter_key   (counter_key),
        .seen_count    (seen_count),
        .pass_count    (pass_count),
        .drop_count    (drop_count)
    );

    vpf_filter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .frame_length  (frame_length),
        .ether_type    (ether_type),
        .tag_control   (tag_control),
        .policy_vlan   (policy_vlan),
        .policy_action (policy_action),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .counted       (counted),
        .counter_key   (counter_key),
        .seen_count    (seen_count),
        .pass_count    (pass_count),
        .drop_count    (drop_count),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("vlan_policy_filter_with_counters_top test failed");
        $finish;
    end

    // Result side: pop is redrawn every cycle from the current stall mix.
    // Sampling happens at the edge, so a result is taken only when pop was
    // already high before that edge.
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One transaction: optional idle cycles first, then hold push with the
    // payload until an edge sees full low. Push is left high on return so
    // back-to-back transactions never drop it for a cycle.
    task automatic send_item(input logic        k,
                             input logic [15:0] flen,
                             input logic [15:0] etype,
                             input logic [15:0] tci,
                             input logic [11:0] pvlan,
                             input logic [1:0]  pact);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        kind          <= k;
        frame_length  <= flen;
        ether_type    <= etype;
        tag_control   <= tci;
        policy_vlan   <= pvlan;
        policy_action <= pact;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Frame and policy wrappers; the unused fields carry random junk so
    // the block is seen to ignore them.
    task automatic send_frame(input logic [15:0] flen,
                              input logic [15:0] etype,
                              input logic [15:0] tci);
        send_item(KIND_FRAME, flen, etype, tci, 12'($urandom), 2'($urandom));
    endtask

    task automatic send_policy(input logic [11:0] pvlan, input logic [1:0] pact);
        send_item(KIND_POLICY, 16'($urandom), 16'($urandom), 16'($urandom), pvlan, pact);
    endtask

    // VLAN ids drawn mostly from a small hot set at both ends of the id
    // space so policy writes and counters keep hitting the same keys.
    function automatic logic [11:0] pick_vlan();
        if ($urandom_range(3) == 0)
            return 12'($urandom_range(4095));
        return ($urandom_range(1) != 0) ? 12'hff0 | 12'($urandom_range(15))
                                        : 12'($urandom_range(15));
    endfunction

    task automatic random_phase(input int items);
        int          pick;
        logic [11:0] vid;
        logic [15:0] tpid;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            vid  = pick_vlan();
            tpid = ($urandom_range(1) != 0) ? TPID_CTAG : TPID_STAG;
            if (pick < 20)
                // policy update, all four action codes
                send_policy(vid, 2'($urandom_range(3)));
            else if (pick < 70)
                // well-formed tagged frame, random priority bits
                send_frame(16'($urandom_range(18, 1518)), tpid,
                           {4'($urandom), vid});
            else if (pick < 75)
                // tagged frame with a jumbo or odd length
                send_frame(16'($urandom_range(18, 65535)), tpid, 16'($urandom));
            else if (pick < 85)
                // untagged; random EtherType, a stray TPID match is fine
                send_frame(16'($urandom_range(14, 65535)), 16'($urandom),
                           16'($urandom));
            else if (pick < 92)
                // runts: below the tagged header length
                send_frame(16'($urandom_range(0, 17)),
                           ($urandom_range(2) == 0) ? 16'($urandom) : tpid,
                           {4'($urandom), vid});
            else
                // pure noise on every field
                send_item(1'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 12'($urandom), 2'($urandom));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        push          <= 1'b0;
        kind          <= KIND_FRAME;
        frame_length  <= '0;
        ether_type    <= '0;
        tag_control   <= '0;
        policy_vlan   <= '0;
        policy_action <= ACT_REMOVE;
        idle_pct       = 0;
        stall_pct      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling. Full stays high through the clearing
        // pass; send_item simply waits it out.
        send_frame(16'd0, 16'h0800, 16'h0000);          // short frame
        send_frame(16'd13, TPID_CTAG, 16'h0005);        // short, tagged TPID
        send_frame(16'd14, 16'h0800, 16'hffff);         // minimal untagged
        send_frame(16'hffff, 16'hffff, 16'h0000);       // untagged, max fields
        send_frame(16'd17, TPID_CTAG, 16'h0005);        // short tagged frame
        send_frame(16'd17, TPID_STAG, 16'h0005);
        send_frame(16'd18, TPID_CTAG, 16'h0000);        // vid 0, absent entry
        send_frame(16'd18, TPID_STAG, 16'hffff);        // vid 4095, absent
        send_frame(16'd64, 16'h8101, 16'h0000);         // near-TPID, untagged
        send_policy(12'd0, ACT_DROP);
        send_policy(12'hfff, ACT_ODD);
        send_policy(12'd5, ACT_PASS);
        send_frame(16'd64, TPID_CTAG, 16'hf000);        // vid 0 drops
        send_frame(16'd64, TPID_STAG, 16'h0fff);        // unnamed entry drops
        send_frame(16'd64, TPID_CTAG, 16'h2005);        // explicit pass
        send_policy(12'd0, ACT_REMOVE);
        send_policy(12'hfff, ACT_PASS);
        send_frame(16'd1518, TPID_CTAG, 16'h0000);      // removed, passes again
        send_frame(16'd1518, TPID_STAG, 16'h8fff);
        send_policy(12'd5, ACT_DROP);
        send_frame(16'd18, TPID_STAG, 16'h0005);        // back-to-back same key
        send_frame(16'd18, TPID_STAG, 16'h0005);
        send_frame(16'd0, TPID_STAG, 16'h0005);         // zero-length tagged
        send_frame(16'd100, 16'h0000, 16'h0000);

        // Random part across the idle/stall mixes.
        random_phase(RANDOM_PER_PHASE);
        idle_pct  = 81;
        stall_pct = 0;
        random_phase(RANDOM_PER_PHASE);
        idle_pct  = 0;
        stall_pct = 81;
        random_phase(RANDOM_PER_PHASE);
        idle_pct  = 35;
        stall_pct = 35;
        random_phase(RANDOM_PER_PHASE);

        // last transaction was taken at this edge
        push <= 1'b0;

        // Drain: every expected result out, then a further wait to catch
        // any stray extra result.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("vlan_policy_filter_with_counters_top test passed");
        else
            $display("vlan_policy_filter_with_counters_top test failed");
        $finish;
    end

endmodule
